@@ design/spmadd_pkg.sv @@
// Shared types for the sparse polynomial merge adder.
package spmadd_pkg;

    // Coefficient and exponent widths of one term.
    localparam int COEFF_W = 32;
    localparam int EXP_W   = 16;

    // One stored term of a polynomial list.
    typedef struct packed {
        logic signed [COEFF_W-1:0] coeff;
        logic        [EXP_W-1:0]   exponent;
    } t_term;

endpackage

@@ design/spmadd_list_mem.sv @@
// Term store of one polynomial: one write port, one registered read port.
module spmadd_list_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  spmadd_pkg::t_term    i_wr_data,
    input  logic [AW-1:0]        i_rd_addr,
    output spmadd_pkg::t_term    o_rd_data
);

    spmadd_pkg::t_term r_mem [DEPTH];
    spmadd_pkg::t_term r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/sparse_polynomial_merge_add_core.sv @@
// Sparse polynomial adder: loads two term lists and merges them into their sum.
// Loading takes one input word per cycle; the input stalls from the closing word until
// the merge has handed its last result to the output register.
// The merge first primes the term store reads, then forms a result whenever the output
// register can take a word (up to 2*MAX_TERMS results).
// Reset (synchronous, active low) empties both lists and drops any pending result.
module sparse_polynomial_merge_add_core #(
    parameter int MAX_TERMS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic signed [31:0] i_term_coeff,
    input  logic [15:0]        i_term_exponent,
    input  logic               i_term_present,
    input  logic               i_list_last,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_sum_coeff,
    output logic [15:0]        o_sum_exponent,
    output logic               o_term_valid,
    output logic               o_coeff_saturated,
    output logic               o_list_overflow,
    output logic               o_last_term
);

    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam logic [CW-1:0] FULL = CW'(MAX_TERMS);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_PREP  = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_i, n_i, r_j, n_j;
    logic          r_closed_a, n_closed_a, r_closed_b, n_closed_b;
    logic          r_ovf, n_ovf;
    logic          r_out_valid, n_out_valid;

    logic signed [31:0] r_sum_coeff, n_sum_coeff;
    logic [15:0]        r_sum_exponent, n_sum_exponent;
    logic               r_term_valid, n_term_valid;
    logic               r_coeff_sat, n_coeff_sat;
    logic               r_list_ovf, n_list_ovf;
    logic               r_last_term, n_last_term;

    logic              in_acc, take, full_a, full_b, wr_a, wr_b;
    logic              adv, load_out;
    logic              have_a, have_b, eq, pick_a, done;
    logic signed [32:0] sum_wide;
    logic              sum_sat;
    logic signed [31:0] sum_clamp;
    logic [AW-1:0]     rd_addr_a, rd_addr_b;
    spmadd_pkg::t_term wr_term, rd_a, rd_b;

    // Term stores of the two polynomials.
    assign wr_term.coeff    = i_term_coeff;
    assign wr_term.exponent = i_term_exponent;

    spmadd_list_mem #(.DEPTH(MAX_TERMS), .AW(AW)) u_mem_a (
        .i_clk     (i_clk),
        .i_wr_en   (wr_a),
        .i_wr_addr (r_cnt_a[AW-1:0]),
        .i_wr_data (wr_term),
        .i_rd_addr (rd_addr_a),
        .o_rd_data (rd_a)
    );

    spmadd_list_mem #(.DEPTH(MAX_TERMS), .AW(AW)) u_mem_b (
        .i_clk     (i_clk),
        .i_wr_en   (wr_b),
        .i_wr_addr (r_cnt_b[AW-1:0]),
        .i_wr_data (wr_term),
        .i_rd_addr (rd_addr_b),
        .o_rd_data (rd_b)
    );

    // Loading side: a word for a closed list is ignored.
    assign o_in_stall = (r_state != ST_LOAD);
    assign in_acc = i_in_valid && !o_in_stall;
    assign take   = in_acc && !(i_op ? r_closed_b : r_closed_a);
    assign full_a = (r_cnt_a == FULL);
    assign full_b = (r_cnt_b == FULL);
    assign wr_a   = take && !i_op && i_term_present && !full_a;
    assign wr_b   = take && i_op && i_term_present && !full_b;

    // Merge step on the terms currently read out at indexes i and j.
    assign have_a = (r_i < r_cnt_a);
    assign have_b = (r_j < r_cnt_b);
    assign eq     = have_a && have_b && (rd_a.exponent == rd_b.exponent);
    assign pick_a = !have_b || (have_a && (rd_a.exponent > rd_b.exponent));

    // Saturating sum of two Q16.16 coefficients.
    assign sum_wide  = {rd_a.coeff[31], rd_a.coeff} + {rd_b.coeff[31], rd_b.coeff};
    assign sum_sat   = (sum_wide[32] != sum_wide[31]);
    assign sum_clamp = sum_sat ? (sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                               : sum_wide[31:0];

    // The output register takes a new word when it is empty or being drained.
    assign adv      = !r_out_valid || !i_out_stall;
    assign load_out = (r_state == ST_MERGE) && adv;

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_closed_a  = r_closed_a;
        n_closed_b  = r_closed_b;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_out_valid = r_out_valid && i_out_stall;
        n_sum_coeff    = r_sum_coeff;
        n_sum_exponent = r_sum_exponent;
        n_term_valid   = r_term_valid;
        n_coeff_sat    = r_coeff_sat;
        n_list_ovf     = r_list_ovf;
        n_last_term    = r_last_term;
        done           = 1'b0;

        unique case (r_state)
            ST_LOAD: begin
                n_i = '0;
                n_j = '0;
                if (wr_a) begin
                    n_cnt_a = r_cnt_a + 1'b1;
                end
                if (wr_b) begin
                    n_cnt_b = r_cnt_b + 1'b1;
                end
                if (take && i_term_present && (i_op ? full_b : full_a)) begin
                    n_ovf = 1'b1;
                end
                if (take && i_list_last) begin
                    if (i_op) begin
                        n_closed_b = 1'b1;
                    end else begin
                        n_closed_a = 1'b1;
                    end
                end
                if (n_closed_a && n_closed_b) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                // Index zero of both stores is read during this cycle.
                n_state = ST_MERGE;
            end
            ST_MERGE: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_list_ovf  = r_ovf;
                    n_coeff_sat = 1'b0;
                    if (!have_a && !have_b) begin
                        // Both lists empty: a single word with no term.
                        n_sum_coeff    = '0;
                        n_sum_exponent = '0;
                        n_term_valid   = 1'b0;
                    end else if (eq) begin
                        n_sum_coeff    = sum_clamp;
                        n_sum_exponent = rd_a.exponent;
                        n_term_valid   = 1'b1;
                        n_coeff_sat    = sum_sat;
                        n_i            = r_i + 1'b1;
                        n_j            = r_j + 1'b1;
                    end else if (pick_a) begin
                        n_sum_coeff    = rd_a.coeff;
                        n_sum_exponent = rd_a.exponent;
                        n_term_valid   = 1'b1;
                        n_i            = r_i + 1'b1;
                    end else begin
                        n_sum_coeff    = rd_b.coeff;
                        n_sum_exponent = rd_b.exponent;
                        n_term_valid   = 1'b1;
                        n_j            = r_j + 1'b1;
                    end
                    done        = (n_i == r_cnt_a) && (n_j == r_cnt_b);
                    n_last_term = done;
                    if (done) begin
                        n_state    = ST_LOAD;
                        n_cnt_a    = '0;
                        n_cnt_b    = '0;
                        n_closed_a = 1'b0;
                        n_closed_b = 1'b0;
                        n_ovf      = 1'b0;
                        n_i        = '0;
                        n_j        = '0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Read addresses follow the next indexes so the read data lines up with i and j.
    assign rd_addr_a = (n_i >= FULL) ? '0 : n_i[AW-1:0];
    assign rd_addr_b = (n_j >= FULL) ? '0 : n_j[AW-1:0];

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_closed_a  <= 1'b0;
            r_closed_b  <= 1'b0;
            r_ovf       <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_closed_a  <= n_closed_a;
            r_closed_b  <= n_closed_b;
            r_ovf       <= n_ovf;
            r_i         <= n_i;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        r_sum_coeff    <= n_sum_coeff;
        r_sum_exponent <= n_sum_exponent;
        r_term_valid   <= n_term_valid;
        r_coeff_sat    <= n_coeff_sat;
        r_list_ovf     <= n_list_ovf;
        r_last_term    <= n_last_term;
    end

    assign o_out_valid       = r_out_valid;
    assign o_sum_coeff       = r_sum_coeff;
    assign o_sum_exponent    = r_sum_exponent;
    assign o_term_valid      = r_term_valid;
    assign o_coeff_saturated = r_coeff_sat;
    assign o_list_overflow   = r_list_ovf;
    assign o_last_term       = r_last_term;

endmodule
